>>> rtl/bb_pkg.sv
package bb_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  // col field wide enough for the largest supported MAX_WIDTH
  localparam int COL_MAX_W     = 12;
  localparam int ROW_W         = 12;
  localparam int PIX_W         = 24;
  localparam int IMG_W_W       = 11;
  localparam int IMG_H_W       = 13;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 13;
  // must be a power of two
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd768;

  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;

  // result kinds of one pixel, in delivery order
  localparam int EM_UP_LEFT  = 0;  // (r-1, c-1)
  localparam int EM_UP_HERE  = 1;  // (r-1, c) at last column
  localparam int EM_ROW_LEFT = 2;  // (r, c-1) on last row
  localparam int EM_ROW_HERE = 3;  // (r, c) on last row, last column
  localparam int EM_N        = 4;

  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic [ROW_W-1:0]     row;
    logic [COL_MAX_W-1:0] col;
    logic                 has_up;
    logic                 has_up2;
    logic                 has_left;
    logic                 has_left2;
    logic                 last_col;
    logic                 last_row;
    logic [EM_N-1:0]      emit;
  } entry_t;

endpackage

>>> rtl/bb_if.sv
interface bb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface bb_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        run_last;
  logic        frame_done;
  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output run_last, output frame_done,
                  input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_row, input out_col, input run_last, input frame_done,
                output ready);
endinterface

interface bb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bb_pkg::CFG_INDEX_W-1:0]     index;
  logic [bb_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/bb_front.sv
module bb_front #(
  parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  bb_pix_if.sink         pixel,
  bb_cfg_if.sink         cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output bb_pkg::entry_t push_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMW   = bb_pkg::COL_MAX_W;
  localparam int RW    = bb_pkg::ROW_W;

  logic [bb_pkg::IMG_W_W-1:0] image_width;
  logic [bb_pkg::IMG_H_W-1:0] image_height;
  logic [COL_W-1:0]           col;
  logic [RW-1:0]              row;
  logic [COL_W-1:0]           col_last;
  logic [RW-1:0]              row_last;
  logic                       last_col;
  logic                       last_row;
  logic                       has_up;
  logic                       has_left;
  logic                       accept;
  logic                       cfg_hit;

  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid &&
                     (cfg.index == bb_pkg::CFG_WIDTH || cfg.index == bb_pkg::CFG_HEIGHT);

  // clamp width to [1, MAX_WIDTH], height to [1, MAX_HEIGHT]
  always_comb begin
    if (image_width == '0) begin
      col_last = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(image_width - 11'd1);
    end
    if (image_height == '0) begin
      row_last = '0;
    end else if (image_height > 13'(bb_pkg::MAX_HEIGHT)) begin
      row_last = RW'(bb_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last = RW'(image_height - 13'd1);
    end
  end

  assign last_col = (col == col_last);
  assign last_row = (row == row_last);
  assign has_up   = (row != '0);
  assign has_left = (col != '0);

  assign pixel.ready = push_ready;
  assign push_valid  = pixel.valid;
  assign accept      = pixel.valid && push_ready;

  always_comb begin
    push_data           = '0;
    push_data.pix       = {pixel.in_red, pixel.in_green, pixel.in_blue};
    push_data.row       = row;
    push_data.col       = CMW'(col);
    push_data.has_up    = has_up;
    push_data.has_up2   = (row >= RW'(2));
    push_data.has_left  = has_left;
    push_data.has_left2 = (col >= COL_W'(2));
    push_data.last_col  = last_col;
    push_data.last_row  = last_row;
    push_data.emit[bb_pkg::EM_UP_LEFT]  = has_up && has_left;
    push_data.emit[bb_pkg::EM_UP_HERE]  = has_up && last_col;
    push_data.emit[bb_pkg::EM_ROW_LEFT] = last_row && has_left;
    push_data.emit[bb_pkg::EM_ROW_HERE] = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb_pkg::IMG_W_RESET;
      image_height <= bb_pkg::IMG_H_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_hit) begin
      if (cfg.index == bb_pkg::CFG_WIDTH) begin
        image_width <= cfg.data[bb_pkg::IMG_W_W-1:0];
      end else begin
        image_height <= cfg.data[bb_pkg::IMG_H_W-1:0];
      end
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : RW'(row + 1'b1);
      end else begin
        col <= COL_W'(col + 1'b1);
      end
    end
  end

endmodule

>>> rtl/bb_queue.sv
module bb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bb_pkg::entry_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bb_pkg::entry_t pop_data
);

  localparam int DEPTH = bb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bb_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= (PTR_W + 1)'(count + 1'b1);
      end else if (pop && !push) begin
        count <= (PTR_W + 1)'(count - 1'b1);
      end
    end
  end

endmodule

>>> rtl/bb_back.sv
module bb_back #(
  parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  bb_pkg::entry_t pop_data,
  bb_res_if.source       result
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PW    = bb_pkg::PIX_W;
  localparam int SUM_W = 12;
  localparam int RECIP_SHIFT = 17;
  localparam logic [17:0] RECIP1 = 18'd131072;
  localparam logic [17:0] RECIP3 = 18'd43691;
  localparam logic [17:0] RECIP9 = 18'd14564;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0]         sum_r;
    logic [SUM_W-1:0]         sum_g;
    logic [SUM_W-1:0]         sum_b;
    logic [3:0]               n;
    logic [bb_pkg::ROW_W-1:0] row;
    logic [9:0]               col;
    logic                     run_last;
    logic                     frame_done;
  } sums_t;

  // rounded mean: floor((2*s + n) / (2*n)), 2n split into m * 2^k, m in {1, 3, 9}
  function automatic logic [7:0] blur_div(input logic [SUM_W-1:0] s, input logic [3:0] n);
    logic [12:0] t;
    logic [11:0] x;
    logic [17:0] rc;
    logic [29:0] p;
    t = {s, 1'b0} + 13'(n);
    case (n)
      4'd1: begin x = 12'(t >> 1); rc = RECIP1; end
      4'd2: begin x = 12'(t >> 2); rc = RECIP1; end
      4'd3: begin x = 12'(t >> 1); rc = RECIP3; end
      4'd4: begin x = 12'(t >> 3); rc = RECIP1; end
      4'd6: begin x = 12'(t >> 2); rc = RECIP3; end
      4'd9: begin x = 12'(t >> 1); rc = RECIP9; end
      default: begin x = 12'(t >> 1); rc = RECIP1; end
    endcase
    p = 30'(x) * 30'(rc);
    return 8'(p >> RECIP_SHIFT);
  endfunction

  state_t           state, state_next;
  bb_pkg::entry_t   cur;
  logic [3:0]       pend;
  logic [3:0]       sel;
  logic [3:0]       pend_left;
  logic [2*PW-1:0]  line_mem [MAX_WIDTH];
  logic [2*PW-1:0]  line_rd;
  logic [PW-1:0]    win [3][3];   // [age][row]: age 0 = newest column; row 2 = current row

  logic             at_up, at_left;
  logic [1:0]       na, nr;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic             emit_fire;

  sums_t            stage;
  logic             s_valid;
  logic             s_take;
  logic             o_adv;
  logic             o_valid;

  assign pop_ready = (state == S_IDLE);

  // line buffers: older row in the upper half, prior row in the lower half
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      line_rd <= line_mem[pop_data.col[COL_W-1:0]];
    end
    if (state == S_LOAD) begin
      line_mem[cur.col[COL_W-1:0]] <= {line_rd[PW-1:0], cur.pix};
    end
  end

  // pick the earliest pending result kind
  always_comb begin
    sel = '0;
    if (pend[bb_pkg::EM_UP_LEFT]) begin
      sel[bb_pkg::EM_UP_LEFT] = 1'b1;
    end else if (pend[bb_pkg::EM_UP_HERE]) begin
      sel[bb_pkg::EM_UP_HERE] = 1'b1;
    end else if (pend[bb_pkg::EM_ROW_LEFT]) begin
      sel[bb_pkg::EM_ROW_LEFT] = 1'b1;
    end else if (pend[bb_pkg::EM_ROW_HERE]) begin
      sel[bb_pkg::EM_ROW_HERE] = 1'b1;
    end
  end

  assign pend_left = pend & ~sel;
  assign at_up     = sel[bb_pkg::EM_UP_LEFT] | sel[bb_pkg::EM_UP_HERE];
  assign at_left   = sel[bb_pkg::EM_UP_LEFT] | sel[bb_pkg::EM_ROW_LEFT];

  // neighbourhood extent inside the image, in columns and rows
  always_comb begin
    if (at_left) begin
      na = cur.has_left2 ? 2'd3 : 2'd2;
    end else begin
      na = cur.has_left ? 2'd2 : 2'd1;
    end
    if (at_up) begin
      nr = cur.has_up2 ? 2'd3 : 2'd2;
    end else begin
      nr = cur.has_up ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        if (a < int'(na) && j >= 3 - int'(nr)) begin
          sum_r = SUM_W'(sum_r + SUM_W'(win[a][j][23:16]));
          sum_g = SUM_W'(sum_g + SUM_W'(win[a][j][15:8]));
          sum_b = SUM_W'(sum_b + SUM_W'(win[a][j][7:0]));
        end
      end
    end
  end

  assign o_adv     = !o_valid || result.ready;
  assign s_take    = !s_valid || o_adv;
  assign emit_fire = (state == S_EMIT) && s_take;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = (cur.emit != '0) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (emit_fire && pend_left == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= '0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          win[a][j] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        pend      <= cur.emit;
        win[2]    <= win[1];
        win[1]    <= win[0];
        win[0][0] <= line_rd[2*PW-1:PW];
        win[0][1] <= line_rd[PW-1:0];
        win[0][2] <= cur.pix;
      end else if (emit_fire) begin
        pend <= pend_left;
      end
      if (s_take) begin
        s_valid <= emit_fire;
      end
      if (o_adv) begin
        o_valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
    end
    if (emit_fire) begin
      stage.sum_r      <= sum_r;
      stage.sum_g      <= sum_g;
      stage.sum_b      <= sum_b;
      stage.n          <= 4'(na) * 4'(nr);
      stage.row        <= at_up ? bb_pkg::ROW_W'(cur.row - 1'b1) : cur.row;
      stage.col        <= at_left ? 10'(cur.col - 1'b1) : 10'(cur.col);
      stage.run_last   <= (pend_left == '0);
      stage.frame_done <= (pend_left == '0) && cur.last_row && cur.last_col;
    end
    if (o_adv && s_valid) begin
      result.out_red    <= blur_div(stage.sum_r, stage.n);
      result.out_green  <= blur_div(stage.sum_g, stage.n);
      result.out_blue   <= blur_div(stage.sum_b, stage.n);
      result.out_row    <= stage.row;
      result.out_col    <= stage.col;
      result.run_last   <= stage.run_last;
      result.frame_done <= stage.frame_done;
    end
  end

  assign result.valid = o_valid;

endmodule

>>> rtl/box_blur_3x3_edge_aware.sv
// Streaming 3x3 box blur of an RGB frame sent in raster order. Each result is the
// rounded-half-up mean of the pixel's neighbours that lie inside the image, tagged with
// its row and column; results trail the input by one row and one pixel, and on the last
// row every input also yields that row's own results (up to four per pixel, run_last
// marks the final one, frame_done the end of the frame). The front end counts position
// and takes a pixel every cycle while its two-entry queue has room; the back end works on
// one pixel at a time, in steps: the single-port line-buffer read, the window load and
// line-buffer write, then one result per cycle while the output path can take it. A
// two-stage output path (sums, then divide) lets the back end continue while a result
// waits. Writing width or height restarts the frame at row 0, column 0.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  bb_pix_if.sink   pixel,
  bb_cfg_if.sink   cfg,
  bb_res_if.source result
);

  logic           q_push_valid;
  logic           q_push_ready;
  bb_pkg::entry_t q_push_data;
  logic           q_pop_valid;
  logic           q_pop_ready;
  bb_pkg::entry_t q_pop_data;

  bb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .cfg        (cfg),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  bb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  bb_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .result    (result)
  );

endmodule
